// ----- hw/rtl/dsp_pkg.sv -----
// ----------------------------------------------------------------------------
// dsp_pkg
// shared types and constants of the shortest path engine
// ----------------------------------------------------------------------------
package dsp_pkg;

    localparam int SLOTS         = 16;
    localparam int NODE_W        = 4;
    localparam int WEIGHT_W      = 16;
    localparam int COST_W        = 20;
    localparam int ADJ_AW        = 2 * NODE_W;
    localparam int ADJ_DEPTH     = SLOTS * SLOTS;
    localparam int NODES_DEFAULT = 16;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEL,
        S_RELAX,
        S_PATH
    } t_state;

    typedef struct packed {
        logic                en;
        logic [ADJ_AW-1:0]   addr;
        logic [WEIGHT_W-1:0] data;
    } t_adj_wr;

endpackage

// ----- hw/rtl/dsp_adj_mem.sv -----
// ----------------------------------------------------------------------------
// dsp_adj_mem
// edge weight store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module dsp_adj_mem (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  dsp_pkg::t_adj_wr                 i_wr,
    input  logic [dsp_pkg::ADJ_AW-1:0]       i_raddr,
    output logic [dsp_pkg::WEIGHT_W-1:0]     o_rdata
);

    logic [dsp_pkg::WEIGHT_W-1:0] mem [dsp_pkg::ADJ_DEPTH];
    logic [dsp_pkg::ADJ_DEPTH-1:0] r_valid;
    logic [dsp_pkg::WEIGHT_W-1:0]  r_rdata;
    logic                          r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= mem[i_raddr];
    end

    // entries never written read as no edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            r_rvalid <= r_valid[i_raddr];
        end
    end

    assign o_rdata  = r_rvalid ? r_rdata : '0;

endmodule

// ----- hw/rtl/dsp_cost_unit.sv -----
// ----------------------------------------------------------------------------
// dsp_cost_unit
// shared saturating add and compare used by selection and relaxation
// ----------------------------------------------------------------------------
module dsp_cost_unit (
    input  logic [dsp_pkg::COST_W-1:0]   i_base,
    input  logic [dsp_pkg::WEIGHT_W-1:0] i_step,
    input  logic [dsp_pkg::COST_W-1:0]   i_ref,
    output logic [dsp_pkg::COST_W-1:0]   o_sum,
    output logic                         o_less
);

    logic [dsp_pkg::COST_W:0] sum_wide;

    assign sum_wide = {1'b0, i_base}
                    + {{(dsp_pkg::COST_W + 1 - dsp_pkg::WEIGHT_W){1'b0}}, i_step};
    assign o_sum    = sum_wide[dsp_pkg::COST_W] ? dsp_pkg::COST_MAX
                                                : sum_wide[dsp_pkg::COST_W-1:0];
    assign o_less   = o_sum < i_ref;

endmodule

// ----- hw/rtl/dijkstra_shortest_path.sv -----
// ----------------------------------------------------------------------------
// dijkstra_shortest_path
// shortest path engine over an undirected weighted graph of up to 16 nodes
// ----------------------------------------------------------------------------
// input channel (i_valid / o_ready) carries edge writes and path queries.
// an edge write gives no result; a weight of zero removes the edge.
// writes to a node beyond the active count are dropped. a query settles
// one node per round: a selection scan of one node per cycle, then a
// relaxation pass of one node per cycle through the edge memory read port
// and the shared add/compare unit. the block accepts nothing while it
// searches. results leave on the output channel (o_valid / i_ready) from
// destination back to source, o_last on the source; an unreachable
// destination gives one transaction with o_found clear. results are held
// in an output register while the receiver stalls, and the path walk
// waits with them. reset (synchronous, active low) empties the graph and
// idles the block.
// ----------------------------------------------------------------------------
module dijkstra_shortest_path #(
    parameter int NODES = dsp_pkg::NODES_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_opcode,
    input  logic [dsp_pkg::NODE_W-1:0]     i_node_a,
    input  logic [dsp_pkg::NODE_W-1:0]     i_node_b,
    input  logic [dsp_pkg::WEIGHT_W-1:0]   i_edge_weight,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [dsp_pkg::NODE_W-1:0]     o_path_node,
    output logic [dsp_pkg::COST_W-1:0]     o_total_cost,
    output logic                           o_found,
    output logic                           o_last
);

    localparam int ACTIVE = (NODES < dsp_pkg::SLOTS) ? NODES : dsp_pkg::SLOTS;
    localparam int CNT_W  = dsp_pkg::NODE_W + 1;
    localparam logic [CNT_W-1:0] ACT_N      = CNT_W'(ACTIVE);
    localparam logic [CNT_W-1:0] ACT_LAST   = CNT_W'(ACTIVE - 1);
    localparam logic [CNT_W-1:0] ROUND_LAST = CNT_W'(ACTIVE - 2);

    dsp_pkg::t_state r_state, n_state;

    logic [dsp_pkg::NODE_W-1:0]   r_src, n_src;
    logic [dsp_pkg::NODE_W-1:0]   r_dst, n_dst;
    logic [dsp_pkg::NODE_W-1:0]   r_node, n_node;
    logic                         r_nf, n_nf;
    logic [CNT_W-1:0]             r_v, n_v;
    logic [CNT_W-1:0]             r_round, n_round;
    logic [dsp_pkg::NODE_W-1:0]   r_pv, n_pv;
    logic                         r_pact, n_pact;
    logic [dsp_pkg::COST_W-1:0]   r_best, n_best;
    logic [dsp_pkg::NODE_W-1:0]   r_sel, n_sel;
    logic                         r_have, n_have;
    logic [dsp_pkg::COST_W-1:0]   r_sel_dist, n_sel_dist;
    logic [dsp_pkg::SLOTS-1:0]    r_done, n_done;
    logic [dsp_pkg::SLOTS-1:0]    r_reached, n_reached;

    logic [dsp_pkg::COST_W-1:0]   r_dist [dsp_pkg::SLOTS];
    logic [dsp_pkg::NODE_W-1:0]   r_pred [dsp_pkg::SLOTS];
    logic                         dist_we;
    logic [dsp_pkg::NODE_W-1:0]   dist_wa;
    logic [dsp_pkg::COST_W-1:0]   dist_wd;
    logic                         pred_we;

    logic                         r_ov, n_ov;
    logic [dsp_pkg::NODE_W-1:0]   r_o_node, n_o_node;
    logic [dsp_pkg::COST_W-1:0]   r_o_cost, n_o_cost;
    logic                         r_o_found, n_o_found;
    logic                         r_o_last, n_o_last;

    dsp_pkg::t_adj_wr             adj_wr;
    logic [dsp_pkg::ADJ_AW-1:0]   adj_raddr;
    logic [dsp_pkg::WEIGHT_W-1:0] adj_rdata;

    logic [dsp_pkg::NODE_W-1:0]   d_idx;
    logic [dsp_pkg::COST_W-1:0]   dist_rd;
    logic [dsp_pkg::COST_W-1:0]   u_base;
    logic [dsp_pkg::WEIGHT_W-1:0] u_step;
    logic [dsp_pkg::COST_W-1:0]   u_ref;
    logic [dsp_pkg::COST_W-1:0]   u_sum;
    logic                         u_less;

    logic                         in_acc;
    logic                         a_ok, b_ok;
    logic                         sel_cand;
    logic                         scan_last;
    logic                         relax_end;
    logic                         relax_hit;
    logic                         out_load;
    logic                         path_miss;
    logic                         path_end;
    logic [dsp_pkg::NODE_W-1:0]   rv_idx;
    logic [dsp_pkg::NODE_W-1:0]   lo_n, hi_n;

    // ------------------------------------------------------------------
    // shared units
    // ------------------------------------------------------------------
    dsp_adj_mem u_adj (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (adj_wr),
        .i_raddr  (adj_raddr),
        .o_rdata  (adj_rdata)
    );

    dsp_cost_unit u_cost (
        .i_base (u_base),
        .i_step (u_step),
        .i_ref  (u_ref),
        .o_sum  (u_sum),
        .o_less (u_less)
    );

    assign o_ready = (r_state == dsp_pkg::S_IDLE);
    assign in_acc  = i_valid && o_ready;
    assign a_ok    = {1'b0, i_node_a} < ACT_N;
    assign b_ok    = {1'b0, i_node_b} < ACT_N;
    assign rv_idx  = r_v[dsp_pkg::NODE_W-1:0];

    // only the triangle with the smaller node first is stored
    always_comb begin
        if (r_sel < rv_idx) begin
            lo_n = r_sel;
            hi_n = rv_idx;
        end else begin
            lo_n = rv_idx;
            hi_n = r_sel;
        end
    end
    assign adj_raddr = {lo_n, hi_n};

    always_comb begin
        adj_wr.en   = (r_state == dsp_pkg::S_IDLE) && in_acc
                   && (i_opcode == dsp_pkg::OP_WRITE) && a_ok && b_ok;
        adj_wr.data = i_edge_weight;
        if (i_node_a < i_node_b) begin
            adj_wr.addr = {i_node_a, i_node_b};
        end else begin
            adj_wr.addr = {i_node_b, i_node_a};
        end
    end

    // single read port of the distance store
    always_comb begin
        case (r_state)
            dsp_pkg::S_RELAX: d_idx = r_pv;
            dsp_pkg::S_PATH:  d_idx = r_dst;
            default:          d_idx = rv_idx;
        endcase
    end
    assign dist_rd = r_dist[d_idx];

    always_comb begin
        if (r_state == dsp_pkg::S_RELAX) begin
            u_base = r_sel_dist;
            u_step = adj_rdata;
            u_ref  = dist_rd;
        end else begin
            u_base = dist_rd;
            u_step = '0;
            u_ref  = r_best;
        end
    end

    assign sel_cand  = !r_done[rv_idx] && r_reached[rv_idx] && (!r_have || u_less);
    assign scan_last = (r_v == ACT_LAST);
    assign relax_end = r_pact && (r_v == ACT_N);
    assign relax_hit = r_pact && !r_done[r_pv] && (adj_rdata != '0)
                    && (!r_reached[r_pv] || u_less);
    assign out_load  = (r_state == dsp_pkg::S_PATH) && (!r_ov || i_ready);
    assign path_miss = r_nf || !r_reached[r_dst];
    assign path_end  = path_miss || (r_node == r_src);

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            dsp_pkg::S_IDLE: begin
                if (in_acc && (i_opcode == dsp_pkg::OP_QUERY)) begin
                    n_state = (a_ok && b_ok) ? dsp_pkg::S_SEL : dsp_pkg::S_PATH;
                end
            end
            dsp_pkg::S_SEL: begin
                if (scan_last) begin
                    n_state = (sel_cand || r_have) ? dsp_pkg::S_RELAX
                                                   : dsp_pkg::S_PATH;
                end
            end
            dsp_pkg::S_RELAX: begin
                if (relax_end) begin
                    n_state = (r_round == ROUND_LAST) ? dsp_pkg::S_PATH
                                                      : dsp_pkg::S_SEL;
                end
            end
            dsp_pkg::S_PATH: begin
                if (out_load && path_end) begin
                    n_state = dsp_pkg::S_IDLE;
                end
            end
            default: n_state = dsp_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // datapath control
    // ------------------------------------------------------------------
    always_comb begin
        n_src      = r_src;
        n_dst      = r_dst;
        n_node     = r_node;
        n_nf       = r_nf;
        n_v        = r_v;
        n_round    = r_round;
        n_pv       = r_pv;
        n_pact     = r_pact;
        n_best     = r_best;
        n_sel      = r_sel;
        n_have     = r_have;
        n_sel_dist = r_sel_dist;
        n_done     = r_done;
        n_reached  = r_reached;
        dist_we    = 1'b0;
        dist_wa    = r_pv;
        dist_wd    = u_sum;
        pred_we    = 1'b0;
        n_ov       = r_ov && !i_ready;
        n_o_node   = r_o_node;
        n_o_cost   = r_o_cost;
        n_o_found  = r_o_found;
        n_o_last   = r_o_last;

        case (r_state)
            dsp_pkg::S_IDLE: begin
                if (in_acc && (i_opcode == dsp_pkg::OP_QUERY)) begin
                    n_src     = i_node_a;
                    n_dst     = i_node_b;
                    n_node    = i_node_b;
                    n_nf      = !(a_ok && b_ok);
                    n_done    = '0;
                    n_reached = '0;
                    n_reached[i_node_a] = 1'b1;
                    n_round   = '0;
                    n_v       = '0;
                    n_have    = 1'b0;
                    dist_we   = a_ok && b_ok;
                    dist_wa   = i_node_a;
                    dist_wd   = '0;
                end
            end
            dsp_pkg::S_SEL: begin
                if (sel_cand) begin
                    n_best = u_sum;
                    n_sel  = rv_idx;
                    n_have = 1'b1;
                end
                if (scan_last) begin
                    n_v        = '0;
                    n_pact     = 1'b0;
                    n_sel_dist = n_best;
                    if (n_have) begin
                        n_done[n_sel] = 1'b1;
                    end
                end else begin
                    n_v = r_v + 1'b1;
                end
            end
            dsp_pkg::S_RELAX: begin
                if (relax_hit) begin
                    dist_we   = 1'b1;
                    pred_we   = 1'b1;
                    n_reached[r_pv] = 1'b1;
                end
                // read issued for node r_v, processed next cycle
                if (r_v != ACT_N) begin
                    n_pv   = rv_idx;
                    n_pact = 1'b1;
                    n_v    = r_v + 1'b1;
                end else begin
                    n_pact = 1'b0;
                end
                if (relax_end) begin
                    n_round = r_round + 1'b1;
                    n_v     = '0;
                    n_have  = 1'b0;
                end
            end
            dsp_pkg::S_PATH: begin
                if (out_load) begin
                    n_ov = 1'b1;
                    if (path_miss) begin
                        n_o_node  = '0;
                        n_o_cost  = '0;
                        n_o_found = 1'b0;
                        n_o_last  = 1'b1;
                    end else begin
                        n_o_node  = r_node;
                        n_o_cost  = dist_rd;
                        n_o_found = 1'b1;
                        n_o_last  = path_end;
                        n_node    = r_pred[r_node];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dsp_pkg::S_IDLE;
            r_done    <= '0;
            r_reached <= '0;
            r_pact    <= 1'b0;
            r_have    <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_done    <= n_done;
            r_reached <= n_reached;
            r_pact    <= n_pact;
            r_have    <= n_have;
            r_ov      <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src      <= n_src;
        r_dst      <= n_dst;
        r_node     <= n_node;
        r_nf       <= n_nf;
        r_v        <= n_v;
        r_round    <= n_round;
        r_pv       <= n_pv;
        r_best     <= n_best;
        r_sel      <= n_sel;
        r_sel_dist <= n_sel_dist;
        r_o_node   <= n_o_node;
        r_o_cost   <= n_o_cost;
        r_o_found  <= n_o_found;
        r_o_last   <= n_o_last;
        if (dist_we) begin
            r_dist[dist_wa] <= dist_wd;
        end
        if (pred_we) begin
            r_pred[r_pv] <= r_sel;
        end
    end

    assign o_valid      = r_ov;
    assign o_path_node  = r_o_node;
    assign o_total_cost = r_o_cost;
    assign o_found      = r_o_found;
    assign o_last       = r_o_last;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_sel_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dsp_pkg::S_RELAX) |-> r_done[r_sel])
        else $error("relaxing from a node that is not settled");

    a_src_reached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dsp_pkg::S_SEL) |-> r_reached[r_src])
        else $error("source lost its reached mark during search");

    a_miss_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> o_last)
        else $error("unreachable result not marked last");

    a_relax_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pred_we |-> (r_state == dsp_pkg::S_RELAX) && r_pact && !r_done[r_pv])
        else $error("predecessor written outside relaxation");

endmodule
